@@ rtl/core/xrfw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_pkg
// Shared types and constants of the XMODEM receiver and flash writer core.
// ----------------------------------------------------------------------------
package xrfw_pkg;

    // Input operations (s_tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_FLASH  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_START = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_START_ADDR  = 2'd0;
    localparam logic [1:0] REG_NAK_RETRIES = 2'd1;
    localparam logic [1:0] REG_START_WAIT  = 2'd2;
    localparam logic [1:0] REG_PACKET_WAIT = 2'd3;

    // Protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam int HDR_LEN       = 3;
    localparam int DATA_LEN      = 128;
    localparam int PACKET_LEN    = HDR_LEN + DATA_LEN + 1;
    localparam int WORDS_PER_PKT = DATA_LEN / 4;
    localparam int WORD_IDX_W    = $clog2(WORDS_PER_PKT);
    localparam int RAM_AW        = WORD_IDX_W + 1;
    localparam int RAM_DEPTH     = 2 * WORDS_PER_PKT;

    // Reset values of the configuration registers
    localparam logic [3:0]  RST_NAK_RETRIES = 4'd10;
    localparam logic [15:0] RST_START_WAIT  = 16'd3000;
    localparam logic [15:0] RST_PACKET_WAIT = 16'd1000;

    // At most one command per input word: everything the back end must emit for it.
    typedef struct packed {
        logic                  flush;
        logic                  bank;
        logic [31:0]           addr;
        logic [WORD_IDX_W:0]   nwords;
        logic [1:0]            tx_cnt;
        logic [7:0]            tx_byte;
        logic                  has_status;
        logic [1:0]            status;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [31:0] addr;
        logic [31:0] word;
        logic [1:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [31:0]       data;
    } ram_wr_t;

endpackage
`default_nettype wire

@@ rtl/core/xrfw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module xrfw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/xrfw_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_fifo
// Short command queue between the protocol front end and the result back end.
// ----------------------------------------------------------------------------
module xrfw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/xrfw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_front
// Protocol front end: accepts input words, runs the XMODEM receive state
// machine, stores packet data into the buffer RAM and queues at most one
// command per input word for the back end.
// ----------------------------------------------------------------------------
module xrfw_front #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         s_tuser,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               fifo_full,
    input  wire xrfw_pkg::done_t    done,
    output logic                    push,
    output xrfw_pkg::cmd_t          cmd,
    output xrfw_pkg::ram_wr_t       ram_wr
);

    import xrfw_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_START  = 4'b0010,
        PH_GATHER = 4'b0100,
        PH_FOLLOW = 4'b1000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [3:0]            tries_reg, tries_next;
    logic [TIMER_BITS-1:0] ticks_reg, ticks_next;
    logic [7:0]            cnt_reg, cnt_next;
    logic [7:0]            block_reg, block_next;
    logic [31:0]           waddr_reg, waddr_next;
    logic [7:0]            hdr0_reg, hdr0_next;
    logic [7:0]            hdr1_reg, hdr1_next;
    logic [7:0]            hdr2_reg, hdr2_next;
    logic [23:0]           lane_reg, lane_next;
    logic                  bank_reg, bank_next;
    logic [1:0]            busy_reg, busy_next;

    logic [31:0]           start_addr_reg;
    logic [3:0]            nak_retries_reg;
    logic [15:0]           start_wait_reg;
    logic [15:0]           packet_wait_reg;

    logic                  accept;
    logic                  do_judge;
    logic                  judge_full;
    logic                  good;
    logic [7:0]            data_cnt;
    logic [7:0]            k;
    logic [WORD_IDX_W:0]   nwords_part;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
        logic [32:0] ext;
        begin
            ext = 33'(v);
            if ((ext >> TIMER_BITS) != 33'd0) begin
                timer_load = '1;
            end else begin
                timer_load = ext[TIMER_BITS-1:0];
            end
        end
    endfunction

    assign s_tready = !fifo_full && !busy_reg[bank_reg];
    assign accept   = s_tvalid && s_tready;

    assign good = (hdr0_reg == CH_SOH) && (hdr1_reg == block_reg) && (hdr2_reg == ~block_reg);
    assign k    = cnt_reg - 8'(HDR_LEN);
    assign data_cnt = (cnt_reg > 8'(HDR_LEN)) ? k : 8'd0;
    assign nwords_part = (WORD_IDX_W + 1)'((9'(data_cnt) + 9'd3) >> 2);

    always_comb begin
        phase_next = phase_reg;
        tries_next = tries_reg;
        ticks_next = ticks_reg;
        cnt_next   = cnt_reg;
        block_next = block_reg;
        waddr_next = waddr_reg;
        hdr0_next  = hdr0_reg;
        hdr1_next  = hdr1_reg;
        hdr2_next  = hdr2_reg;
        lane_next  = lane_reg;
        bank_next  = bank_reg;
        cmd        = '0;
        ram_wr     = '0;
        do_judge   = 1'b0;
        judge_full = 1'b0;

        if (accept) begin
            case (s_tuser)
                OP_START: begin
                    cnt_next   = '0;
                    hdr0_next  = '0;
                    hdr1_next  = '0;
                    hdr2_next  = '0;
                    block_next = 8'd1;
                    waddr_next = start_addr_reg;
                    if (nak_retries_reg == '0) begin
                        tries_next     = '0;
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_NO_START;
                        phase_next     = PH_IDLE;
                    end else begin
                        tries_next  = nak_retries_reg - 4'd1;
                        ticks_next  = timer_load(start_wait_reg);
                        phase_next  = PH_START;
                        cmd.tx_cnt  = 2'd1;
                        cmd.tx_byte = CH_NAK;
                    end
                end
                OP_BYTE: begin
                    case (phase_reg)
                        PH_START, PH_FOLLOW: begin
                            if (phase_reg == PH_FOLLOW && s_tdata == CH_EOT) begin
                                cmd.tx_cnt     = 2'd2;
                                cmd.tx_byte    = CH_ACK;
                                cmd.has_status = 1'b1;
                                cmd.status     = ST_DONE;
                                phase_next     = PH_IDLE;
                            end else if (phase_reg == PH_FOLLOW || s_tdata == CH_SOH) begin
                                // The byte opens a new packet.
                                cnt_next   = 8'd1;
                                hdr0_next  = s_tdata;
                                hdr1_next  = '0;
                                hdr2_next  = '0;
                                ticks_next = timer_load(packet_wait_reg);
                                phase_next = PH_GATHER;
                            end
                        end
                        PH_GATHER: begin
                            if (cnt_reg == 8'd1) begin
                                hdr1_next = s_tdata;
                            end else if (cnt_reg == 8'd2) begin
                                hdr2_next = s_tdata;
                            end else if (cnt_reg < 8'(HDR_LEN + DATA_LEN)) begin
                                case (k[1:0])
                                    2'd0: lane_next = {16'd0, s_tdata};
                                    2'd1: lane_next[15:8] = s_tdata;
                                    2'd2: lane_next[23:16] = s_tdata;
                                    default: begin
                                        ram_wr.en   = 1'b1;
                                        ram_wr.addr = {bank_reg, k[WORD_IDX_W+1:2]};
                                        ram_wr.data = {s_tdata, lane_reg};
                                    end
                                endcase
                            end
                            cnt_next = cnt_reg + 8'd1;
                            if (cnt_reg == 8'(PACKET_LEN - 1)) begin
                                do_judge   = 1'b1;
                                judge_full = 1'b1;
                                phase_next = PH_FOLLOW;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        if (ticks_reg <= TIMER_BITS'(1)) begin
                            ticks_next = '0;
                            case (phase_reg)
                                PH_START: begin
                                    if (tries_reg != '0) begin
                                        tries_next  = tries_reg - 4'd1;
                                        ticks_next  = timer_load(start_wait_reg);
                                        cmd.tx_cnt  = 2'd1;
                                        cmd.tx_byte = CH_NAK;
                                    end else begin
                                        cmd.has_status = 1'b1;
                                        cmd.status     = ST_NO_START;
                                        phase_next     = PH_IDLE;
                                    end
                                end
                                PH_GATHER: begin
                                    do_judge       = 1'b1;
                                    cmd.has_status = 1'b1;
                                    cmd.status     = ST_TIMEOUT;
                                    phase_next     = PH_IDLE;
                                end
                                default: begin
                                    cmd.has_status = 1'b1;
                                    cmd.status     = ST_TIMEOUT;
                                    phase_next     = PH_IDLE;
                                end
                            endcase
                        end else begin
                            ticks_next = ticks_reg - TIMER_BITS'(1);
                        end
                    end
                end
                default: ;
            endcase

            if (do_judge) begin
                if (good) begin
                    cmd.flush   = 1'b1;
                    cmd.bank    = bank_reg;
                    cmd.addr    = waddr_reg;
                    cmd.nwords  = judge_full ? (WORD_IDX_W + 1)'(WORDS_PER_PKT) : nwords_part;
                    cmd.tx_cnt  = 2'd1;
                    cmd.tx_byte = CH_ACK;
                    waddr_next  = waddr_reg + 32'(DATA_LEN);
                    block_next  = block_reg + 8'd1;
                    bank_next   = ~bank_reg;
                    // A packet cut short leaves a partly filled word behind.
                    if (!judge_full && data_cnt[1:0] != 2'd0) begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = {bank_reg, data_cnt[WORD_IDX_W+1:2]};
                        ram_wr.data = {8'd0, lane_reg};
                    end
                end else begin
                    cmd.tx_cnt  = 2'd1;
                    cmd.tx_byte = CH_NAK;
                end
                cnt_next  = '0;
                hdr0_next = '0;
                hdr1_next = '0;
                hdr2_next = '0;
            end
        end
    end

    assign push = cmd.flush || (cmd.tx_cnt != 2'd0) || cmd.has_status;

    always_comb begin
        busy_next = busy_reg;
        if (done.valid) begin
            busy_next[done.bank] = 1'b0;
        end
        if (push && cmd.flush) begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tries_reg <= '0;
            ticks_reg <= '0;
            cnt_reg   <= '0;
            block_reg <= 8'd1;
            waddr_reg <= '0;
            hdr0_reg  <= '0;
            hdr1_reg  <= '0;
            hdr2_reg  <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            tries_reg <= tries_next;
            ticks_reg <= ticks_next;
            cnt_reg   <= cnt_next;
            block_reg <= block_next;
            waddr_reg <= waddr_next;
            hdr0_reg  <= hdr0_next;
            hdr1_reg  <= hdr1_next;
            hdr2_reg  <= hdr2_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        lane_reg <= lane_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg  <= '0;
            nak_retries_reg <= RST_NAK_RETRIES;
            start_wait_reg  <= RST_START_WAIT;
            packet_wait_reg <= RST_PACKET_WAIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_ADDR:  start_addr_reg  <= cfg_data;
                REG_NAK_RETRIES: nak_retries_reg <= cfg_data[3:0];
                REG_START_WAIT:  start_wait_reg  <= cfg_data[15:0];
                REG_PACKET_WAIT: packet_wait_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/xrfw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_back
// Result back end: takes commands from the queue and emits the flash word
// writes, transmit bytes and final status through a registered output.
// ----------------------------------------------------------------------------
module xrfw_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire xrfw_pkg::cmd_t                  head,
    input  wire logic                            fifo_empty,
    output logic                                 pop,
    output logic                                 ram_rd_en,
    output logic      [xrfw_pkg::RAM_AW-1:0]     ram_rd_addr,
    input  wire logic [31:0]                     ram_rd_data,
    output xrfw_pkg::done_t                      done,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output xrfw_pkg::res_t                       res
);

    import xrfw_pkg::*;

    typedef enum logic [4:0] {
        BK_IDLE   = 5'b00001,
        BK_FL_RD  = 5'b00010,
        BK_FL_OUT = 5'b00100,
        BK_TX     = 5'b01000,
        BK_STAT   = 5'b10000
    } bstate_t;

    bstate_t               state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]            txl_reg, txl_next;
    res_t                  res_reg, res_next;
    logic                  valid_reg, valid_next;
    logic                  out_free;
    logic                  load;
    bstate_t               after_flush;

    assign out_free = !valid_reg || m_tready;
    assign after_flush = (cmd_reg.tx_cnt != 2'd0) ? BK_TX :
                         (cmd_reg.has_status ? BK_STAT : BK_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        txl_next    = txl_reg;
        res_next    = res_reg;
        pop         = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = {cmd_reg.bank, idx_reg};
        done        = '0;
        load        = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!fifo_empty) begin
                    pop      = 1'b1;
                    cmd_next = head;
                    idx_next = '0;
                    txl_next = head.tx_cnt;
                    if (head.flush) begin
                        state_next = BK_FL_RD;
                    end else if (head.tx_cnt != 2'd0) begin
                        state_next = BK_TX;
                    end else begin
                        state_next = BK_STAT;
                    end
                end
            end
            BK_FL_RD: begin
                ram_rd_en  = 1'b1;
                state_next = BK_FL_OUT;
            end
            BK_FL_OUT: begin
                if (out_free) begin
                    load             = 1'b1;
                    res_next         = '0;
                    res_next.kind    = KIND_FLASH;
                    res_next.addr    = cmd_reg.addr + 32'({idx_reg, 2'b00});
                    // Words past the received data of a short packet read as zero.
                    res_next.word    = ({1'b0, idx_reg} < cmd_reg.nwords) ? ram_rd_data : 32'd0;
                    res_next.last    = (idx_reg == '1) && (cmd_reg.tx_cnt == 2'd0) &&
                                       !cmd_reg.has_status;
                    if (idx_reg == '1) begin
                        done.valid = 1'b1;
                        done.bank  = cmd_reg.bank;
                        state_next = after_flush;
                    end else begin
                        idx_next   = idx_reg + WORD_IDX_W'(1);
                        state_next = BK_FL_RD;
                    end
                end
            end
            BK_TX: begin
                if (out_free) begin
                    load             = 1'b1;
                    res_next         = '0;
                    res_next.kind    = KIND_TX;
                    res_next.tx_byte = cmd_reg.tx_byte;
                    res_next.last    = (txl_reg == 2'd1) && !cmd_reg.has_status;
                    txl_next         = txl_reg - 2'd1;
                    if (txl_reg == 2'd1) begin
                        state_next = cmd_reg.has_status ? BK_STAT : BK_IDLE;
                    end
                end
            end
            BK_STAT: begin
                if (out_free) begin
                    load            = 1'b1;
                    res_next        = '0;
                    res_next.kind   = KIND_STATUS;
                    res_next.status = cmd_reg.status;
                    res_next.last   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            txl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            txl_reg   <= txl_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule
`default_nettype wire

@@ rtl/core/xmodem_receiver_flash_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_receiver_flash_writer_core
// XMODEM receiver (128-byte packets) that turns good packets into 32-bit
// flash word writes and answers with ACK, NAK and a final status.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while the command queue has room and
// the packet buffer bank being filled is not still being read out.
// A transmit byte or status passes the command queue, the back end's command
// register and the output register; a flash word write also passes a RAM read.
// A good packet drains as 32 word writes (RAM read, then output register), then ACK.
// Reset is synchronous, active low, and clears all control state; the packet
// buffer RAM is not cleared, a per-packet word count masks stale entries.
// ----------------------------------------------------------------------------
module xmodem_receiver_flash_writer_core #(
    parameter int TIMER_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] tx_byte, [39:8] flash_address,
                                        // [71:40] flash_word, [73:72] status
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    import xrfw_pkg::*;

    localparam int CMD_W = $bits(cmd_t);

    cmd_t              front_cmd;
    cmd_t              head_cmd;
    logic              push;
    logic              pop;
    logic              fifo_full;
    logic              fifo_empty;
    logic [CMD_W-1:0]  head_bits;
    done_t             done;
    ram_wr_t           ram_wr;
    logic              ram_rd_en;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic [31:0]       ram_rd_data;
    res_t              res;

    xrfw_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .done      (done),
        .push      (push),
        .cmd       (front_cmd),
        .ram_wr    (ram_wr)
    );

    xrfw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .head      (head_bits),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    assign head_cmd = cmd_t'(head_bits);

    xrfw_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    xrfw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head_cmd),
        .fifo_empty  (fifo_empty),
        .pop         (pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .done        (done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    assign m_tdata = {6'd0, res.status, res.word, res.addr, res.tx_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
`default_nettype wire

@@ rtl/core/xrfw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrfw_checker
// Port-level checks on the result stream of the receiver core.
// ----------------------------------------------------------------------------
module xrfw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    import xrfw_pkg::*;

    // A stalled word stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled word keeps its payload.
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // A flash word write is always followed by the ACK of its packet.
    a_flash_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FLASH |-> !m_tlast)
        else $error("flash word write marked last");

    // The final status ends the results of its input word.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status result not marked last");

    // Reset empties the output register.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind xmodem_receiver_flash_writer_core xrfw_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XMODEM receiver and flash writer core. Each
// test drives start commands, serial bytes and millisecond ticks. A local
// copy of the receiver protocol predicts every transmit byte, flash word
// write and final status, and each result word is checked against it.
// ----------------------------------------------------------------------------
module tb;
    import xrfw_pkg::*;

    localparam int TIMEOUT_NS = 10_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [2:0] {
        XF_IDLE,
        XF_WAIT_SOH,
        XF_GATHER,
        XF_FOLLOW
    } xfer_phase_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Receiver state as the block should hold it.
    logic [31:0]  cfg_start_addr = '0;
    logic [3:0]   cfg_retries = RST_NAK_RETRIES;
    logic [15:0]  cfg_start_wait = RST_START_WAIT;
    logic [15:0]  cfg_packet_wait = RST_PACKET_WAIT;
    xfer_phase_e  phase = XF_IDLE;
    logic [3:0]   tries_left = '0;
    logic [15:0]  ticks_left = '0;
    int           byte_cnt = 0;
    logic [7:0]   blk_num = 8'd1;
    logic [31:0]  wr_addr = '0;
    logic [7:0]   hdr [HDR_LEN];
    logic [7:0]   pkt_data [DATA_LEN];

    res_t owed_results [$];
    res_t want_res;
    int   mismatch_count = 0;
    int   items_taken = 0;
    logic steady = 1'b0;

    xmodem_receiver_flash_writer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Alternate between random stalls and a long stretch with none.
    initial forever begin
        steady = 1'b0;
        repeat (3000) @(posedge aclk);
        steady = 1'b1;
        repeat (1500) @(posedge aclk);
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 16);
    end

    // ------------------------------------------------------------------
    // Protocol prediction
    // ------------------------------------------------------------------
    function automatic void post_result(logic [1:0] kind, logic [7:0] tx, logic [31:0] addr,
                                        logic [31:0] word, logic [1:0] st);
        res_t r;
        r = '{kind, tx, addr, word, st, 1'b0};
        owed_results.push_back(r);
    endfunction

    function automatic void clear_packet();
        foreach (hdr[i]) hdr[i] = '0;
        foreach (pkt_data[i]) pkt_data[i] = '0;
        byte_cnt = 0;
    endfunction

    function automatic void end_transfer(logic [1:0] st);
        post_result(KIND_STATUS, '0, '0, '0, st);
        phase = XF_IDLE;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (byte_cnt < HDR_LEN) begin
            hdr[byte_cnt] = b;
        end else if (byte_cnt < HDR_LEN + DATA_LEN) begin
            pkt_data[byte_cnt - HDR_LEN] = b;
        end
        if (byte_cnt < PACKET_LEN) begin
            byte_cnt++;
        end
    endfunction

    function automatic void judge_packet();
        logic good;
        good = hdr[0] == CH_SOH && hdr[1] == blk_num && hdr[2] == ~blk_num;
        if (good) begin
            for (int i = 0; i < WORDS_PER_PKT; i++) begin
                post_result(KIND_FLASH, '0, wr_addr + 32'(4 * i),
                            {pkt_data[4*i+3], pkt_data[4*i+2], pkt_data[4*i+1], pkt_data[4*i]},
                            '0);
            end
            post_result(KIND_TX, CH_ACK, '0, '0, '0);
            wr_addr = wr_addr + 32'(DATA_LEN);
            blk_num = blk_num + 8'd1;
        end else begin
            post_result(KIND_TX, CH_NAK, '0, '0, '0);
        end
        clear_packet();
    endfunction

    // Applies one input word; returns whether the block acts on it at all.
    function automatic bit advance_transfer(logic [1:0] op, logic [7:0] b);
        int  first_new;
        bit  acted;
        first_new = owed_results.size();
        acted = (op == OP_START) || ((op == OP_BYTE || op == OP_TICK) && phase != XF_IDLE);
        case (op)
            OP_START: begin
                clear_packet();
                blk_num = 8'd1;
                wr_addr = cfg_start_addr;
                if (cfg_retries == 0) begin
                    tries_left = '0;
                    end_transfer(ST_NO_START);
                end else begin
                    tries_left = cfg_retries - 4'd1;
                    ticks_left = cfg_start_wait;
                    phase = XF_WAIT_SOH;
                    post_result(KIND_TX, CH_NAK, '0, '0, '0);
                end
            end
            OP_BYTE: begin
                case (phase)
                    XF_WAIT_SOH: begin
                        if (b == CH_SOH) begin
                            clear_packet();
                            store_byte(b);
                            ticks_left = cfg_packet_wait;
                            phase = XF_GATHER;
                        end
                    end
                    XF_GATHER: begin
                        store_byte(b);
                        if (byte_cnt >= PACKET_LEN) begin
                            judge_packet();
                            phase = XF_FOLLOW;
                        end
                    end
                    XF_FOLLOW: begin
                        if (b == CH_EOT) begin
                            post_result(KIND_TX, CH_ACK, '0, '0, '0);
                            post_result(KIND_TX, CH_ACK, '0, '0, '0);
                            end_transfer(ST_DONE);
                        end else begin
                            clear_packet();
                            store_byte(b);
                            ticks_left = cfg_packet_wait;
                            phase = XF_GATHER;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (phase != XF_IDLE) begin
                    if (ticks_left <= 16'd1) begin
                        ticks_left = '0;
                        if (phase == XF_WAIT_SOH) begin
                            if (tries_left > 0) begin
                                tries_left--;
                                ticks_left = cfg_start_wait;
                                post_result(KIND_TX, CH_NAK, '0, '0, '0);
                            end else begin
                                end_transfer(ST_NO_START);
                            end
                        end else if (phase == XF_GATHER) begin
                            // A packet cut short is still answered before the timeout.
                            judge_packet();
                            end_transfer(ST_TIMEOUT);
                        end else begin
                            end_transfer(ST_TIMEOUT);
                        end
                    end else begin
                        ticks_left--;
                    end
                end
            end
            default: ;
        endcase
        if (owed_results.size() > first_new) begin
            owed_results[owed_results.size() - 1].last = 1'b1;
        end
        return acted;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want_res = owed_results.pop_front();
                if (m_tuser !== want_res.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want_res.kind));
                if (m_tdata[7:0] !== want_res.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, want %h",
                                              m_tdata[7:0], want_res.tx_byte));
                if (m_tdata[39:8] !== want_res.addr)
                    report_mismatch($sformatf("flash_address %h, want %h",
                                              m_tdata[39:8], want_res.addr));
                if (m_tdata[71:40] !== want_res.word)
                    report_mismatch($sformatf("flash_word %h, want %h",
                                              m_tdata[71:40], want_res.word));
                if (m_tdata[73:72] !== want_res.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_tdata[73:72], want_res.status));
                if (m_tlast !== want_res.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want_res.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        if (advance_transfer(op, b)) begin
            items_taken++;
        end
    endtask

    // Sends the first count bytes of a packet with the given header.
    task automatic send_packet(input logic [7:0] lead, input logic [7:0] num,
                               input logic [7:0] num_inv, input int count);
        for (int i = 0; i < count; i++) begin
            case (i)
                0: send_item(OP_BYTE, lead);
                1: send_item(OP_BYTE, num);
                2: send_item(OP_BYTE, num_inv);
                default: send_item(OP_BYTE, 8'($urandom));
            endcase
        end
    endtask

    task automatic send_good_packet();
        send_packet(CH_SOH, blk_num, ~blk_num, PACKET_LEN);
    endtask

    task automatic run_out_timer();
        while (phase != XF_IDLE) begin
            send_item(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_START_ADDR:  cfg_start_addr = value;
            REG_NAK_RETRIES: cfg_retries = value[3:0];
            REG_START_WAIT:  cfg_start_wait = value[15:0];
            REG_PACKET_WAIT: cfg_packet_wait = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] addr, input logic [31:0] retries,
                             input logic [31:0] swait, input logic [31:0] pwait);
        wait_drained();
        write_reg(REG_START_ADDR, addr);
        write_reg(REG_NAK_RETRIES, retries);
        write_reg(REG_START_WAIT, swait);
        write_reg(REG_PACKET_WAIT, pwait);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Ignored words while idle, then one packet with the reset settings.
    task automatic test_reset_settings();
        send_item(2'd3, 8'hFF);
        send_item(OP_BYTE, CH_SOH);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        repeat (3) send_item(OP_TICK, 8'($urandom));
        send_item(2'd3, 8'h55);
        send_good_packet();
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, CH_EOT);
        send_item(OP_BYTE, 8'h01);
    endtask

    task automatic test_start_phase();
        configure(32'h0, 2, 3, 8);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, CH_EOT);
        run_out_timer();
        // No attempts at all: the start fails at once.
        configure(32'h0, 0, 3, 8);
        send_item(OP_START, 8'h00);
        // A zero wait behaves as a single tick.
        configure(32'h0, 1, 0, 0);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, CH_SOH);
        send_item(OP_TICK, 8'h00);
        // Restart in the middle of a packet.
        configure(32'h0000_1000, 3, 5, 8);
        send_item(OP_START, 8'h00);
        send_packet(CH_SOH, blk_num, ~blk_num, 10);
        send_item(OP_START, 8'h00);
        send_good_packet();
        send_item(OP_BYTE, CH_EOT);
    endtask

    task automatic test_packet_judging();
        configure(32'h2000_0000, 4, 20, 6);
        send_item(OP_START, 8'h00);
        send_good_packet();
        send_packet(CH_SOH, blk_num + 8'd1, ~(blk_num + 8'd1), PACKET_LEN);
        send_packet(CH_SOH, blk_num, blk_num, PACKET_LEN);
        // A follower that is not EOT starts the next packet, here a bad one.
        send_packet(8'h02, blk_num, ~blk_num, PACKET_LEN);
        send_good_packet();
        run_out_timer();
    endtask

    task automatic test_short_packets();
        configure(32'h0000_0040, 2, 10, 4);
        send_item(OP_START, 8'h00);
        send_packet(CH_SOH, blk_num, ~blk_num, 20);
        run_out_timer();
        send_item(OP_START, 8'h00);
        send_packet(CH_SOH, blk_num, ~blk_num, 2);
        run_out_timer();
    endtask

    task automatic test_extreme_settings();
        configure(32'hFFFF_FFC0, 15, 16'hFFFF, 16'hFFFF);
        send_item(OP_START, 8'h00);
        repeat (3) send_item(OP_TICK, 8'h00);
        send_good_packet();
        repeat (2) send_item(OP_TICK, 8'h00);
        send_good_packet();
        send_item(OP_BYTE, CH_EOT);
        configure(32'hFFFF_FFFF, 1, 1, 1);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_good_packet();
        send_item(OP_TICK, 8'h00);
    endtask

    task automatic test_random_transfers();
        int base;
        int pick;
        base = items_taken;
        while (items_taken - base < 260) begin
            if ($urandom_range(1)) begin
                configure(32'($urandom), $urandom_range(0, 3), $urandom_range(0, 12),
                          $urandom_range(0, 12));
            end
            send_item(OP_START, 8'($urandom));
            repeat ($urandom_range(0, 3)) send_item(2'($urandom_range(1, 3)), 8'($urandom));
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_good_packet();
                end else if (pick < 80) begin
                    send_packet(CH_SOH, blk_num ^ 8'($urandom_range(1, 255)),
                                ~blk_num ^ 8'($urandom_range(0, 1)), PACKET_LEN);
                end else if (pick < 90) begin
                    send_packet(CH_SOH, blk_num, ~blk_num, $urandom_range(1, PACKET_LEN - 1));
                    run_out_timer();
                end else begin
                    repeat ($urandom_range(1, 8)) send_item(2'($urandom), 8'($urandom));
                end
            end
            if ($urandom_range(1)) begin
                send_item(OP_BYTE, CH_EOT);
            end
            run_out_timer();
        end
    endtask

    initial begin
        clear_packet();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_settings();
        test_start_phase();
        test_packet_judging();
        test_short_packets();
        test_extreme_settings();
        test_random_transfers();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("xmodem_receiver_flash_writer_core regression: pass");
        end else begin
            $display("xmodem_receiver_flash_writer_core regression: fail");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("xmodem_receiver_flash_writer_core regression: fail");
        $finish;
    end

endmodule
